>>> hdl/assert_macros.svh
// Assertion helpers included by float32_arith_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an implication on every rising edge of clk while rst_n is high.
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

>>> hdl/fau_pkg.sv
package fau_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALIGN,
    S_DPRE,
    S_DIV,
    S_NORM,
    S_DENORM,
    S_ROUND,
    S_OUT
  } state_t;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] RM_RTZ = 2'd0;
  localparam logic [1:0] RM_RNE = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] MAXF_BITS = 32'h7F7F_FFFF;

  localparam int unsigned EXP_W = 13;
  localparam int unsigned DIV_STEPS = 41;

  function automatic logic [31:0] overflow_bits(input logic s, input logic [1:0] mode);
    logic to_inf;
    to_inf = (mode == RM_RNE) || (mode == RM_RUP && !s) || (mode == RM_RDN && s);
    return {s, to_inf ? INF_BITS[30:0] : MAXF_BITS[30:0]};
  endfunction

endpackage

>>> hdl/float32_arith_unit.sv
// IEEE 754 binary32 add, subtract, multiply and divide with four rounding modes,
// subnormals, infinities, signed zeros and a canonical quiet NaN (0x7FC00000).
// One item is handled at a time: in_ready is high only when the unit is idle, and
// the result stays on out_result_bits until taken. Special operands are resolved
// in the decode state. An add or subtract aligns by shifting 8 or 1 bits a cycle
// and then runs the normalizing shift. A multiply uses the single 24x24 multiplier.
// A divide first prenormalizes subnormal operands, shifting one bit per cycle, then
// produces 41 quotient bits by radix-2 restoring division, plus a sticky bit.
// Subnormal results are shifted right before rounding.
`include "assert_macros.svh"

module float32_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits
);
  import fau_pkg::*;

  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r;
  logic [1:0]              cmd_r, cmd_nxt;
  logic [31:0]             a_r, a_nxt, b_r, b_nxt;
  logic                    sign_r, sign_nxt;
  logic                    sub_r, sub_nxt;
  logic signed [EXP_W-1:0] exp_r, exp_nxt;
  logic [63:0]             sig_r, sig_nxt;
  logic [63:0]             opb_r, opb_nxt;
  logic [24:0]             rem_r, rem_nxt;
  logic [6:0]              cnt_r, cnt_nxt;
  logic [31:0]             res_r, res_nxt;

  logic                    sa, sb, a_inf, b_inf, a_zero, b_zero, swap;
  logic [7:0]              xa, xb;
  logic [23:0]             ma, mb;
  logic signed [EXP_W-1:0] ea, eb, dd, ebias, shamt;
  logic [63:0]             sum;
  logic [24:0]             rdiff;
  logic                    ge, inc, half, rest;
  logic [23:0]             q24;
  logic [30:0]             rnd_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= RM_RNE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    sign_r <= sign_nxt;
    sub_r  <= sub_nxt;
    exp_r  <= exp_nxt;
    sig_r  <= sig_nxt;
    opb_r  <= opb_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_result_bits = res_r;

  always_comb begin
    sa     = a_r[31];
    sb     = b_r[31];
    xa     = a_r[30:23];
    xb     = b_r[30:23];
    ma     = {(xa != 8'd0), a_r[22:0]};
    mb     = {(xb != 8'd0), b_r[22:0]};
    ea     = (xa == 8'd0) ? -13'sd149 : $signed({5'd0, xa}) - 13'sd150;
    eb     = (xb == 8'd0) ? -13'sd149 : $signed({5'd0, xb}) - 13'sd150;
    a_inf  = (xa == 8'hFF);
    b_inf  = (xb == 8'hFF);
    a_zero = (ma == 24'd0);
    b_zero = (mb == 24'd0);
    swap   = (ea < eb) || (ea == eb && ma < mb);
    dd     = swap ? eb - ea : ea - eb;
    sum    = sub_r ? sig_r - opb_r : sig_r + opb_r;
    rdiff  = rem_r - {1'b0, opb_r[23:0]};
    ge     = (rem_r >= {1'b0, opb_r[23:0]});
    ebias  = exp_r + 13'sd189;
    shamt  = 13'sd1 - ebias;
    q24    = sig_r[62:39];
    half   = sig_r[38];
    rest   = |sig_r[37:0];
    unique case (mode_r)
      RM_RNE: inc = half && (rest || q24[0]);
      RM_RUP: inc = !sign_r && (half || rest);
      RM_RDN: inc = sign_r && (half || rest);
      default: inc = 1'b0;
    endcase
    rnd_bits = {exp_r[7:0] - 8'd1, 23'd0} + {7'd0, q24} + {30'd0, inc};

    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    sign_nxt  = sign_r;
    sub_nxt   = sub_r;
    exp_nxt   = exp_r;
    sig_nxt   = sig_r;
    opb_nxt   = opb_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          a_nxt     = in_operand_a;
          b_nxt     = (in_cmd == CMD_SUB) ? {~in_operand_b[31], in_operand_b[30:0]}
                                          : in_operand_b;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        if ((a_inf && a_r[22:0] != 23'd0) || (b_inf && b_r[22:0] != 23'd0)) begin
          res_nxt = QNAN_BITS;
        end else begin
          case (cmd_r) inside
            CMD_ADD, CMD_SUB: begin
              if (a_inf || b_inf) begin
                res_nxt = (a_inf && b_inf && sa != sb) ? QNAN_BITS : (a_inf ? a_r : b_r);
              end else if (a_zero && b_zero) begin
                res_nxt = (sa == sb) ? {sa, 31'd0} : {(mode_r == RM_RDN), 31'd0};
              end else if (a_zero) begin
                res_nxt = b_r;
              end else if (b_zero) begin
                res_nxt = a_r;
              end else begin
                sign_nxt  = swap ? sb : sa;
                sub_nxt   = (sa != sb);
                exp_nxt   = (swap ? eb : ea) - 13'sd38;
                sig_nxt   = {2'd0, (swap ? mb : ma), 38'd0};
                opb_nxt   = {2'd0, (swap ? ma : mb), 38'd0};
                cnt_nxt   = (dd > 13'sd62) ? 7'd63 : dd[6:0];
                state_nxt = S_ALIGN;
              end
            end
            CMD_MUL: begin
              if (a_inf || b_inf) begin
                res_nxt = ((a_inf && !b_inf && b_zero) || (b_inf && !a_inf && a_zero))
                          ? QNAN_BITS : {sa ^ sb, INF_BITS[30:0]};
              end else if (a_zero || b_zero) begin
                res_nxt = {sa ^ sb, 31'd0};
              end else begin
                sign_nxt  = sa ^ sb;
                exp_nxt   = ea + eb;
                sig_nxt   = {16'd0, {24'd0, ma} * {24'd0, mb}};
                state_nxt = S_NORM;
              end
            end
            default: begin
              if (a_inf && b_inf) begin
                res_nxt = QNAN_BITS;
              end else if (a_inf) begin
                res_nxt = {sa ^ sb, INF_BITS[30:0]};
              end else if (b_inf) begin
                res_nxt = {sa ^ sb, 31'd0};
              end else if (b_zero) begin
                res_nxt = a_zero ? QNAN_BITS : {sa ^ sb, INF_BITS[30:0]};
              end else if (a_zero) begin
                res_nxt = {sa ^ sb, 31'd0};
              end else begin
                sign_nxt  = sa ^ sb;
                exp_nxt   = ea - eb - 13'sd41;
                sig_nxt   = {40'd0, ma};
                opb_nxt   = {40'd0, mb};
                state_nxt = S_DPRE;
              end
            end
          endcase
        end
      end
      S_ALIGN: begin
        if (cnt_r >= 7'd8) begin
          opb_nxt = {8'd0, opb_r[63:8]} | {63'd0, |opb_r[7:0]};
          cnt_nxt = cnt_r - 7'd8;
        end else if (cnt_r != 7'd0) begin
          opb_nxt = {1'b0, opb_r[63:1]} | {63'd0, opb_r[0]};
          cnt_nxt = cnt_r - 7'd1;
        end else if (sum == 64'd0) begin
          res_nxt   = {(mode_r == RM_RDN), 31'd0};
          state_nxt = S_OUT;
        end else begin
          sig_nxt   = sum;
          state_nxt = S_NORM;
        end
      end
      S_DPRE: begin
        if (!sig_r[23]) begin
          sig_nxt = {sig_r[62:0], 1'b0};
          exp_nxt = exp_r - 13'sd1;
        end else if (!opb_r[23]) begin
          opb_nxt = {opb_r[62:0], 1'b0};
          exp_nxt = exp_r + 13'sd1;
        end else begin
          rem_nxt   = sig_r[24:0];
          sig_nxt   = 64'd0;
          cnt_nxt   = 7'(DIV_STEPS);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r != 7'd0) begin
          sig_nxt = {sig_r[62:0], ge};
          rem_nxt = {(ge ? rdiff[23:0] : rem_r[23:0]), 1'b0};
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          sig_nxt   = {sig_r[62:0], (rem_r != 25'd0)};
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sig_r[62:55] == 8'd0) begin
          sig_nxt = {sig_r[55:0], 8'd0};
          exp_nxt = exp_r - 13'sd8;
        end else if (!sig_r[62]) begin
          sig_nxt = {sig_r[62:0], 1'b0};
          exp_nxt = exp_r - 13'sd1;
        end else if (ebias >= 13'sd255) begin
          res_nxt   = overflow_bits(sign_r, mode_r);
          state_nxt = S_OUT;
        end else if (ebias < 13'sd1) begin
          exp_nxt   = 13'sd1;
          cnt_nxt   = (shamt > 13'sd63) ? 7'd63 : shamt[6:0];
          state_nxt = S_DENORM;
        end else begin
          exp_nxt   = ebias;
          state_nxt = S_ROUND;
        end
      end
      S_DENORM: begin
        if (cnt_r >= 7'd8) begin
          sig_nxt = {8'd0, sig_r[63:8]} | {63'd0, |sig_r[7:0]};
          cnt_nxt = cnt_r - 7'd8;
        end else if (cnt_r != 7'd0) begin
          sig_nxt = {1'b0, sig_r[63:1]} | {63'd0, sig_r[0]};
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        res_nxt   = (rnd_bits >= INF_BITS[30:0]) ? overflow_bits(sign_r, mode_r)
                                                 : {sign_r, rnd_bits};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_ready_excl, in_ready, !out_valid, "in_ready and out_valid both high")
  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `ASSERT_CLK(a_div_count, (state_r == S_DIV && cnt_r != 7'd0) |=> (cnt_r == $past(cnt_r) - 7'd1), "division step count")
  `ASSERT_IMPL(a_norm_top, state_r == S_NORM, !sig_r[63], "significand overflowed")

endmodule
